FILE: sv/kpm_pkg.sv
// Shared types, keyword table and constants for the keyword presence matcher.
`timescale 1ns / 1ps

package kpm_pkg;

    localparam int KW_COUNT   = 43;
    localparam int KW_MAX_LEN = 19;
    localparam int MASK_W     = 43;
    localparam int COUNT_W    = 6;
    localparam int OUT_DATA_W = 56;
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);

    typedef logic [MASK_W-1:0]       t_mask;
    typedef logic [COUNT_W-1:0]      t_count;
    typedef logic [KW_MAX_LEN*8-1:0] t_kw_text;

    // Last character of each keyword sits in the lowest byte; unused bytes are zero.
    localparam t_kw_text KW_TEXT [KW_COUNT] = '{
        t_kw_text'("python"), t_kw_text'("javascript"), t_kw_text'("typescript"),
        t_kw_text'("rust"), t_kw_text'("go"), t_kw_text'("c++"), t_kw_text'("java"),
        t_kw_text'("kotlin"), t_kw_text'("react"), t_kw_text'("vue"),
        t_kw_text'("angular"), t_kw_text'("node.js"), t_kw_text'("express"),
        t_kw_text'("django"), t_kw_text'("fastapi"), t_kw_text'("postgresql"),
        t_kw_text'("mysql"), t_kw_text'("mongodb"), t_kw_text'("redis"),
        t_kw_text'("elasticsearch"), t_kw_text'("kubernetes"), t_kw_text'("docker"),
        t_kw_text'("aws"), t_kw_text'("gcp"), t_kw_text'("azure"),
        t_kw_text'("terraform"), t_kw_text'("helm"), t_kw_text'("machine learning"),
        t_kw_text'("deep learning"), t_kw_text'("pytorch"), t_kw_text'("tensorflow"),
        t_kw_text'("scikit-learn"), t_kw_text'("system design"),
        t_kw_text'("distributed systems"), t_kw_text'("microservices"),
        t_kw_text'("kafka"), t_kw_text'("rabbitmq"), t_kw_text'("graphql"),
        t_kw_text'("rest"), t_kw_text'("grpc"), t_kw_text'("protobuf"),
        t_kw_text'("ci/cd"), t_kw_text'("github actions")
    };

endpackage

FILE: sv/kpm_front.sv
// Front end: case folding, byte window, keyword compare and sticky hit mask.
`timescale 1ns / 1ps

module kpm_front #(
    parameter int WINDOW_BYTES = 19
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_byte,
    input  logic           i_last,
    output logic           o_push,
    output kpm_pkg::t_mask o_push_mask,
    input  logic           i_push_ready
);

    logic [7:0]     r_window [WINDOW_BYTES];
    logic [7:0]     n_window [WINDOW_BYTES];
    kpm_pkg::t_mask r_mask;
    kpm_pkg::t_mask n_mask;
    logic [7:0]     folded;
    logic           accept;

    assign o_ready = i_push_ready;
    assign accept  = i_valid && o_ready;

    always_comb begin
        folded = (i_byte inside {[8'h41:8'h5A]}) ? (i_byte + 8'h20) : i_byte;
        n_window[0] = folded;
        for (int j = 1; j < WINDOW_BYTES; j++) begin
            n_window[j] = r_window[j-1];
        end
    end

    always_comb begin
        logic       hit;
        logic [7:0] pat;
        n_mask = r_mask;
        for (int k = 0; k < kpm_pkg::KW_COUNT; k++) begin
            hit = 1'b1;
            for (int j = 0; j < kpm_pkg::KW_MAX_LEN; j++) begin
                pat = kpm_pkg::KW_TEXT[k][8*j +: 8];
                if (pat != 8'h00 && n_window[j] != pat) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                n_mask[k] = 1'b1;
            end
        end
    end

    assign o_push      = accept && i_last;
    assign o_push_mask = n_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < WINDOW_BYTES; j++) begin
                r_window[j] <= 8'h00;
            end
            r_mask <= '0;
        end else if (accept) begin
            if (i_last) begin
                for (int j = 0; j < WINDOW_BYTES; j++) begin
                    r_window[j] <= 8'h00;
                end
                r_mask <= '0;
            end else begin
                r_window <= n_window;
                r_mask   <= n_mask;
            end
        end
    end

endmodule

FILE: sv/kpm_queue.sv
// Short queue of finished hit masks between the front and back ends.
`timescale 1ns / 1ps

module kpm_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  kpm_pkg::t_mask i_push_mask,
    output logic           o_push_ready,
    output logic           o_pop_valid,
    output kpm_pkg::t_mask o_pop_mask,
    input  logic           i_pop
);

    kpm_pkg::t_mask                 r_mem [kpm_pkg::Q_DEPTH];
    logic [kpm_pkg::Q_PTR_W-1:0]    r_wptr;
    logic [kpm_pkg::Q_PTR_W-1:0]    r_rptr;
    logic [kpm_pkg::Q_PTR_W:0]      r_count;
    logic                           do_push;
    logic                           do_pop;

    assign o_push_ready = (r_count != (kpm_pkg::Q_PTR_W+1)'(kpm_pkg::Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_mask   = r_mem[r_rptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_push_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: sv/kpm_back.sv
// Back end: hit count and registered result request.
`timescale 1ns / 1ps

module kpm_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  kpm_pkg::t_mask i_mask,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output kpm_pkg::t_mask o_mask,
    output kpm_pkg::t_count o_count
);

    localparam int CHUNKS = (kpm_pkg::MASK_W + 7) / 8;

    function automatic logic [3:0] popcnt8(input logic [7:0] v);
        logic [3:0] c;
        c = '0;
        for (int i = 0; i < 8; i++) begin
            c = c + 4'(v[i]);
        end
        return c;
    endfunction

    logic                    r_valid;
    kpm_pkg::t_mask          r_mask;
    kpm_pkg::t_count         r_count;
    logic [CHUNKS*8-1:0]     padded;
    kpm_pkg::t_count         n_count;

    always_comb begin
        padded  = (CHUNKS*8)'(i_mask);
        n_count = '0;
        for (int c = 0; c < CHUNKS; c++) begin
            n_count = n_count + kpm_pkg::t_count'(popcnt8(padded[8*c +: 8]));
        end
    end

    assign o_pop   = i_valid && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_mask  = r_mask;
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_mask  <= i_mask;
            r_count <= n_count;
        end
    end

endmodule

FILE: sv/keyword_presence_matcher.sv
// Top level of the keyword presence matcher.
// Throughput: one text byte per cycle across text boundaries too, while the queue has room.
// The result request shows once the final byte's hit mask has passed through the mask queue
// and then the count and output register.
// Keyword compare runs on all table entries at once against the byte window.
// Reset (synchronous, active low) clears the window, hit mask, queue and result request.
`timescale 1ns / 1ps

module keyword_presence_matcher #(
    parameter int WINDOW_BYTES = 19
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [kpm_pkg::OUT_DATA_W-1:0] m_axis_tdata // [42:0] found_mask, [48:43] found_count
);

    logic            push;
    kpm_pkg::t_mask  push_mask;
    logic            push_ready;
    logic            pop_valid;
    kpm_pkg::t_mask  pop_mask;
    logic            pop;
    kpm_pkg::t_mask  out_mask;
    kpm_pkg::t_count out_count;

    kpm_front #(
        .WINDOW_BYTES(WINDOW_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_byte       (s_axis_tdata),
        .i_last       (s_axis_tlast),
        .o_push       (push),
        .o_push_mask  (push_mask),
        .i_push_ready (push_ready)
    );

    kpm_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_mask  (push_mask),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_pop_mask   (pop_mask),
        .i_pop        (pop)
    );

    kpm_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pop_valid),
        .i_mask  (pop_mask),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_mask  (out_mask),
        .o_count (out_count)
    );

    assign m_axis_tdata = {
        (kpm_pkg::OUT_DATA_W - kpm_pkg::MASK_W - kpm_pkg::COUNT_W)'(0),
        out_count,
        out_mask
    };

endmodule

FILE: sv/kpm_checker.sv
// Port checker for the keyword presence matcher and its bind statement.
`timescale 1ns / 1ps

module kpm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [kpm_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    a_no_result_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result request straight after reset");

    a_count_matches_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($countones(m_axis_tdata[kpm_pkg::MASK_W-1:0]) ==
            int'(m_axis_tdata[kpm_pkg::MASK_W +: kpm_pkg::COUNT_W])))
        else $error("found count disagrees with found mask");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[kpm_pkg::OUT_DATA_W-1:kpm_pkg::MASK_W+kpm_pkg::COUNT_W] == '0))
        else $error("padding bits set in result");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result request dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result data changed while stalled");

endmodule

bind keyword_presence_matcher kpm_checker u_kpm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
